// File: design/u8sd_pkg.sv
// shared types and codes for the utf-8 sequence decoder
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int unsigned CpW = 21;
	localparam int unsigned CntW = 3;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NULL       = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_ILLEGAL    = 2'd3
	} status_t;

	localparam logic [CntW-1:0] MaxAvail = 3'd4;

	// lead byte classified, window length checked
	typedef struct packed {
		status_t         status;
		logic [CntW-1:0] need;
		logic [6:0]      lead_bits;
		logic [7:0]      byte_second;
		logic [7:0]      byte_third;
		logic [7:0]      byte_fourth;
	} lead_t;

	// continuation bytes checked and value assembled
	typedef struct packed {
		status_t         status;
		logic [CpW-1:0]  value;
		logic [CntW-1:0] need;
	} asm_t;

	typedef struct packed {
		status_t         status;
		logic [CpW-1:0]  code_point;
		logic [CntW-1:0] byte_count;
	} rsp_t;

endpackage

// File: design/u8sd_channels.sv
// valid/ready channels for the decoder's byte window and result word
`timescale 1ns / 1ps

interface u8sd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_first;
	logic [7:0] byte_second;
	logic [7:0] byte_third;
	logic [7:0] byte_fourth;
	logic [2:0] bytes_available;

	modport source (output valid, byte_first, byte_second, byte_third, byte_fourth,
		bytes_available, input ready);
	modport sink (input valid, byte_first, byte_second, byte_third, byte_fourth,
		bytes_available, output ready);
endinterface

interface u8sd_out_if import u8sd_pkg::*;;
	logic            valid;
	logic            ready;
	status_t         status;
	logic [CpW-1:0]  code_point;
	logic [CntW-1:0] byte_count;

	modport source (output valid, status, code_point, byte_count, input ready);
	modport sink (input valid, status, code_point, byte_count, output ready);
endinterface

// File: design/u8sd_lead.sv
// stage 1: lead byte classification and available-count check
`timescale 1ns / 1ps

module u8sd_lead import u8sd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  logic [7:0] byte_first,
	input  logic [7:0] byte_second,
	input  logic [7:0] byte_third,
	input  logic [7:0] byte_fourth,
	input  logic [2:0] bytes_available,
	output logic       dn_valid,
	input  logic       dn_ready,
	output lead_t      dn
);

	logic            valid_s1;
	lead_t           lead_s1;
	lead_t           lead_d;
	logic [CntW-1:0] avail;

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn       = lead_s1;

	always_comb begin
		avail = (bytes_available > MaxAvail) ? MaxAvail : bytes_available;
		lead_d.status      = ST_OK;
		lead_d.need        = 3'd1;
		lead_d.lead_bits   = byte_first[6:0];
		lead_d.byte_second = byte_second;
		lead_d.byte_third  = byte_third;
		lead_d.byte_fourth = byte_fourth;
		if (byte_first[7] == 1'b0) begin
			lead_d.need = 3'd1;
		end else if (byte_first[7:5] == 3'b110) begin
			lead_d.need      = 3'd2;
			lead_d.lead_bits = {2'b00, byte_first[4:0]};
		end else if (byte_first[7:4] == 4'b1110) begin
			lead_d.need      = 3'd3;
			lead_d.lead_bits = {3'b000, byte_first[3:0]};
		end else if (byte_first[7:3] == 5'b11110) begin
			lead_d.need      = 3'd4;
			lead_d.lead_bits = {4'b0000, byte_first[2:0]};
		end else begin
			lead_d.status = ST_ILLEGAL;
		end
		// an empty window is incomplete whatever the lead
		if (avail == 3'd0) begin
			lead_d.status = ST_INCOMPLETE;
		end else if (lead_d.status == ST_OK && avail < lead_d.need) begin
			lead_d.status = ST_INCOMPLETE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lead_s1 <= lead_d;
		end
	end

endmodule

// File: design/u8sd_assemble.sv
// stage 2: continuation byte check and code point assembly
`timescale 1ns / 1ps

module u8sd_assemble import u8sd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  lead_t up,
	output logic  dn_valid,
	input  logic  dn_ready,
	output asm_t  dn
);

	logic       valid_s2;
	asm_t       asm_s2;
	asm_t       asm_d;
	logic [2:0] cont_ok;
	logic [2:0] cont_used;

	assign up_ready = !valid_s2 || dn_ready;
	assign dn_valid = valid_s2;
	assign dn       = asm_s2;

	always_comb begin
		cont_ok   = {up.byte_fourth[7:6] == 2'b10, up.byte_third[7:6] == 2'b10,
			up.byte_second[7:6] == 2'b10};
		cont_used = {up.need > 3'd3, up.need > 3'd2, up.need > 3'd1};
		asm_d.status = up.status;
		asm_d.need   = up.need;
		case (up.need)
			3'd2:    asm_d.value = {10'd0, up.lead_bits[4:0], up.byte_second[5:0]};
			3'd3:    asm_d.value = {5'd0, up.lead_bits[3:0], up.byte_second[5:0],
				up.byte_third[5:0]};
			3'd4:    asm_d.value = {up.lead_bits[2:0], up.byte_second[5:0],
				up.byte_third[5:0], up.byte_fourth[5:0]};
			default: asm_d.value = {14'd0, up.lead_bits};
		endcase
		// bytes past the sequence length are never looked at
		if (up.status == ST_OK && (cont_used & ~cont_ok) != 3'b000) begin
			asm_d.status = ST_ILLEGAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			asm_s2 <= asm_d;
		end
	end

endmodule

// File: design/u8sd_finish.sv
// stage 3: null detection and result word register
`timescale 1ns / 1ps

module u8sd_finish import u8sd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  asm_t up,
	output logic dn_valid,
	input  logic dn_ready,
	output rsp_t dn
);

	logic valid_s3;
	rsp_t rsp_s3;
	rsp_t rsp_d;

	assign up_ready = !valid_s3 || dn_ready;
	assign dn_valid = valid_s3;
	assign dn       = rsp_s3;

	always_comb begin
		if (up.status != ST_OK) begin
			rsp_d.status     = up.status;
			rsp_d.code_point = '0;
			rsp_d.byte_count = '0;
		end else begin
			rsp_d.status     = (up.value == '0) ? ST_NULL : ST_OK;
			rsp_d.code_point = up.value;
			rsp_d.byte_count = up.need;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rsp_s3 <= rsp_d;
		end
	end

endmodule

// File: design/utf8_sequence_decode_unit.sv
// top level of the pipelined utf-8 sequence decoder
//
//  channel  dir  payload
//  din      in   byte_first..byte_fourth, bytes_available
//  dout     out  status, code_point, byte_count
//
// three register stages: lead classify, continuation check/assemble, finish
// one word per cycle in and out while dout.ready holds; a word passes the lead,
// assemble and finish registers in turn before dout.valid rises
// reset clears the stage valid bits only; no state survives between words
// a stage holds its word while the next one is full and stalled; ready is
// the chain of those hold conditions back from dout.ready
`timescale 1ns / 1ps

module utf8_sequence_decode_unit import u8sd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	u8sd_in_if.sink   din,
	u8sd_out_if.source dout
);

	logic  lead_valid;
	logic  lead_ready;
	lead_t lead;
	logic  asm_valid;
	logic  asm_ready;
	asm_t  asm_w;
	rsp_t  rsp;

	u8sd_lead u_lead (
		.clk             (clk),
		.arst_n          (arst_n),
		.up_valid        (din.valid),
		.up_ready        (din.ready),
		.byte_first      (din.byte_first),
		.byte_second     (din.byte_second),
		.byte_third      (din.byte_third),
		.byte_fourth     (din.byte_fourth),
		.bytes_available (din.bytes_available),
		.dn_valid        (lead_valid),
		.dn_ready        (lead_ready),
		.dn              (lead)
	);

	u8sd_assemble u_assemble (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (lead_valid),
		.up_ready (lead_ready),
		.up       (lead),
		.dn_valid (asm_valid),
		.dn_ready (asm_ready),
		.dn       (asm_w)
	);

	u8sd_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (asm_valid),
		.up_ready (asm_ready),
		.up       (asm_w),
		.dn_valid (dout.valid),
		.dn_ready (dout.ready),
		.dn       (rsp)
	);

	assign dout.status     = rsp.status;
	assign dout.code_point = rsp.code_point;
	assign dout.byte_count = rsp.byte_count;

endmodule

// File: verif/utf8_sequence_decode_unit_tb.sv
// self-checking testbench for the utf-8 sequence decoder: directed table, then random windows
`timescale 1ns / 1ps

module utf8_sequence_decode_unit_tb;
	import u8sd_pkg::*;

	localparam int RandomWindows = 1300;
	localparam int PauseAt = 650;
	localparam int StallLimit = 2000;
	localparam int DrainCycles = 10;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic [7:0] byte_third;
		logic [7:0] byte_fourth;
		logic [2:0] bytes_available;
		bit         typed;
		rsp_t       rsp;
	} window_row_t;

	localparam rsp_t NoRsp = '{ST_OK, 21'd0, 3'd0};
	localparam rsp_t Incomplete = '{ST_INCOMPLETE, 21'd0, 3'd0};
	localparam rsp_t Illegal = '{ST_ILLEGAL, 21'd0, 3'd0};

	localparam int TableRows = 25;
	localparam window_row_t WindowTable [TableRows] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, '{ST_NULL, 21'h0, 3'd1}},
		'{8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1, '{ST_OK, 21'h7F, 3'd1}},
		// nothing available
		'{8'h41, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, Incomplete},
		// count above four saturates
		'{8'h41, 8'h00, 8'h00, 8'h00, 3'd7, 1'b1, '{ST_OK, 21'h41, 3'd1}},
		// bad leads
		'{8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1, Illegal},
		'{8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b1, Illegal},
		'{8'hF8, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1, Illegal},
		'{8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2, 1'b0, NoRsp},
		'{8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1, 1'b1, Incomplete},
		'{8'hC3, 8'h28, 8'h00, 8'h00, 3'd2, 1'b1, Illegal},
		// overlong encodings of zero still flag null
		'{8'hC0, 8'h80, 8'h00, 8'h00, 3'd2, 1'b1, '{ST_NULL, 21'h0, 3'd2}},
		'{8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3, 1'b0, NoRsp},
		'{8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2, 1'b1, Incomplete},
		'{8'hE2, 8'h82, 8'h28, 8'h00, 3'd3, 1'b1, Illegal},
		'{8'hE0, 8'h80, 8'h80, 8'h00, 3'd3, 1'b1, '{ST_NULL, 21'h0, 3'd3}},
		// surrogate passes through
		'{8'hED, 8'hA0, 8'h80, 8'h00, 3'd3, 1'b0, NoRsp},
		'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4, 1'b0, NoRsp},
		'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3, 1'b1, Incomplete},
		// above the unicode range, not rejected
		'{8'hF4, 8'h90, 8'h80, 8'h80, 3'd4, 1'b0, NoRsp},
		'{8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd5, 1'b1, '{ST_OK, 21'h1FFFFF, 3'd4}},
		'{8'hF0, 8'h80, 8'h80, 8'h80, 3'd6, 1'b1, '{ST_NULL, 21'h0, 3'd4}},
		// length check wins over bad continuation bytes
		'{8'hE2, 8'hFF, 8'hFF, 8'hFF, 3'd2, 1'b1, Incomplete},
		'{8'hF0, 8'h9F, 8'h28, 8'h80, 3'd4, 1'b1, Illegal},
		'{8'hF0, 8'h9F, 8'h98, 8'hFF, 3'd4, 1'b1, Illegal},
		// bytes past the sequence are ignored
		'{8'h24, 8'hFF, 8'hFF, 8'hFF, 3'd1, 1'b1, '{ST_OK, 21'h24, 3'd1}}
	};

	logic clk;
	logic arst_n;

	u8sd_in_if  din_bus ();
	u8sd_out_if dout_bus ();

	utf8_sequence_decode_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_bus),
		.dout  (dout_bus)
	);

	rsp_t pending_chars [$];
	int   mismatch_count = 0;
	int   windows_sent = 0;
	int   chars_checked = 0;
	int   status_seen [4] = '{0, 0, 0, 0};
	int   tx_burst = 0;
	int   rx_burst = 0;
	int   idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// decodes the character that starts at the first byte of the window
	function automatic rsp_t decode_window(input logic [7:0] b0, b1, b2, b3,
			input logic [2:0] avail);
		rsp_t        r;
		logic [31:0] win;
		logic [2:0]  navail;
		logic [2:0]  need;
		logic [20:0] acc;
		logic [7:0]  cont;
		r = Incomplete;
		win = {b3, b2, b1, b0};
		navail = (avail > MaxAvail) ? MaxAvail : avail;
		if (navail == 3'd0)
			return r;
		if (!b0[7]) begin
			r.status = (b0 == 8'h00) ? ST_NULL : ST_OK;
			r.code_point = {14'd0, b0[6:0]};
			r.byte_count = 3'd1;
			return r;
		end
		if (b0[7:5] == 3'b110) begin
			acc = {16'd0, b0[4:0]};
			need = 3'd2;
		end else if (b0[7:4] == 4'b1110) begin
			acc = {17'd0, b0[3:0]};
			need = 3'd3;
		end else if (b0[7:3] == 5'b11110) begin
			acc = {18'd0, b0[2:0]};
			need = 3'd4;
		end else begin
			return Illegal;
		end
		if (navail < need)
			return Incomplete;
		for (int k = 1; k < need; k++) begin
			cont = win[8*k +: 8];
			if (cont[7:6] != 2'b10)
				return Illegal;
			acc = {acc[14:0], cont[5:0]};
		end
		r.status = (acc == 21'd0) ? ST_NULL : ST_OK;
		r.code_point = acc;
		r.byte_count = need;
		return r;
	endfunction

	task automatic send_window(input logic [7:0] b0, b1, b2, b3, input logic [2:0] avail,
			input bit typed, input rsp_t typed_rsp);
		int gap;
		if (tx_burst > 0) begin
			gap = 0;
			tx_burst--;
		end else begin
			gap = $urandom_range(0, 19);
			if ($urandom_range(0, 15) == 0)
				tx_burst = $urandom_range(20, 60);
		end
		@(negedge clk);
		if (gap > 0) begin
			din_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.byte_first <= b0;
		din_bus.byte_second <= b1;
		din_bus.byte_third <= b2;
		din_bus.byte_fourth <= b3;
		din_bus.bytes_available <= avail;
		do @(posedge clk); while (!din_bus.ready);
		pending_chars.push_back(typed ? typed_rsp : decode_window(b0, b1, b2, b3, avail));
		windows_sent++;
	endtask

	// window source
	initial begin : window_source
		logic [7:0] w [4];
		logic [2:0] avail;
		int         kind;
		int         len;
		int         j;
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.byte_first = 8'h00;
		din_bus.byte_second = 8'h00;
		din_bus.byte_third = 8'h00;
		din_bus.byte_fourth = 8'h00;
		din_bus.bytes_available = 3'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < TableRows; r++)
			send_window(WindowTable[r].byte_first, WindowTable[r].byte_second,
				WindowTable[r].byte_third, WindowTable[r].byte_fourth,
				WindowTable[r].bytes_available, WindowTable[r].typed, WindowTable[r].rsp);

		for (int n = 0; n < RandomWindows; n++) begin
			if (n == PauseAt) begin
				// hold off until every result is back
				@(negedge clk);
				din_bus.valid <= 1'b0;
				while (pending_chars.size() != 0)
					@(posedge clk);
			end
			for (int i = 0; i < 4; i++)
				w[i] = 8'($urandom);
			kind = $urandom_range(0, 99);
			len = $urandom_range(1, 4);
			case (len)
				1: w[0][7] = 1'b0;
				2: w[0][7:5] = 3'b110;
				3: w[0][7:4] = 4'b1110;
				default: w[0][7:3] = 5'b11110;
			endcase
			for (int i = 1; i < len; i++)
				w[i][7:6] = 2'b10;
			if (kind < 60) begin
				avail = 3'($urandom_range(len, 7));
			end else if (kind < 75) begin
				// short window
				avail = 3'($urandom_range(0, len - 1));
			end else if (kind < 90) begin
				// corrupt one continuation byte, if the sequence has any
				if (len > 1) begin
					j = $urandom_range(1, len - 1);
					case ($urandom_range(0, 2))
						0: w[j][7:6] = 2'b00;
						1: w[j][7:6] = 2'b01;
						default: w[j][7:6] = 2'b11;
					endcase
				end
				avail = 3'($urandom_range(len, 7));
			end else begin
				for (int i = 0; i < 4; i++)
					w[i] = 8'($urandom);
				avail = 3'($urandom_range(0, 7));
			end
			send_window(w[0], w[1], w[2], w[3], avail, 1'b0, NoRsp);
		end

		@(negedge clk);
		din_bus.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d windows (%0d directed), checked %0d results", windows_sent,
			TableRows, chars_checked);
		$display("results by status: %0d decoded, %0d null, %0d incomplete, %0d illegal",
			status_seen[ST_OK], status_seen[ST_NULL], status_seen[ST_INCOMPLETE],
			status_seen[ST_ILLEGAL]);
		if (mismatch_count == 0)
			$display("utf8_sequence_decode_unit_tb: done, clean");
		else
			$display("utf8_sequence_decode_unit_tb: done, errors");
		$finish;
	end

	// result sink and checker
	initial begin : result_sink
		int   stall;
		rsp_t want;
		dout_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_burst > 0) begin
				stall = 0;
				rx_burst--;
			end else begin
				stall = $urandom_range(0, 19);
				if ($urandom_range(0, 15) == 0)
					rx_burst = $urandom_range(20, 60);
			end
			@(negedge clk);
			if (stall > 0) begin
				dout_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			dout_bus.ready <= 1'b1;
			do @(posedge clk); while (!dout_bus.valid);
			if (pending_chars.size() == 0) begin
				$error("result word with nothing expected: status %0d code_point %0h",
					dout_bus.status, dout_bus.code_point);
				mismatch_count++;
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				status_seen[dout_bus.status]++;
				if (dout_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, dout_bus.status);
					mismatch_count++;
				end
				if (dout_bus.code_point !== want.code_point) begin
					$error("code_point: expected %0h, got %0h", want.code_point,
						dout_bus.code_point);
					mismatch_count++;
				end
				if (dout_bus.byte_count !== want.byte_count) begin
					$error("byte_count: expected %0d, got %0d", want.byte_count,
						dout_bus.byte_count);
					mismatch_count++;
				end
			end
		end
	end

	// ends the run when neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("utf8_sequence_decode_unit_tb: done, errors");
				$finish;
			end
		end
	end

endmodule

// File: files.f
design/u8sd_pkg.sv
design/u8sd_channels.sv
design/u8sd_lead.sv
design/u8sd_assemble.sv
design/u8sd_finish.sv
design/utf8_sequence_decode_unit.sv
verif/utf8_sequence_decode_unit_tb.sv
